// File: design/ase_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ase_pkg: shared types and constants of the angle sensor EMA/zeroing core
// Formats, register codes, op codes, sequencer states and control bundle.
// ----------------------------------------------------------------------------
package ase_pkg;

  // fixed-point formats
  localparam int ADC_BITS  = 12;
  localparam int FRAC_BITS = 8;
  localparam int VAL_BITS  = ADC_BITS + FRAC_BITS;   // filter / zero, unsigned
  localparam int ANG_BITS  = VAL_BITS + 1;           // angle, signed
  localparam int COEF_W    = 16;                     // Q0.16 coefficients
  localparam int DIFF_W    = VAL_BITS + 2;           // signed difference, room to negate
  localparam int PROD_W    = DIFF_W + COEF_W + 1;    // signed product
  localparam int RND_W     = PROD_W - COEF_W;        // product rounded to integer
  localparam int SUM_W     = RND_W + 1;              // filter plus step

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = VAL_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_VALID_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NEGATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEG_PER_CNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ZERO = 3'd5;

  // register reset values
  localparam logic [ADC_BITS-1:0] RST_VALID_MIN    = ADC_BITS'(50);
  localparam logic [ADC_BITS-1:0] RST_VALID_MAX    = ADC_BITS'(4045);
  localparam logic [COEF_W-1:0]   RST_ALPHA        = COEF_W'(6554);
  localparam logic                RST_ANGLE_NEGATE = 1'b0;
  localparam logic [COEF_W-1:0]   RST_DEG_PER_CNT  = COEF_W'(655);
  localparam logic [VAL_BITS-1:0] RST_DEFAULT_ZERO = VAL_BITS'(524288);

  // item operations; code 3 is unused and only reports state
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_LOAD    = 2'd2
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FMUL,
    ST_FUPD,
    ST_AMUL,
    ST_AOUT
  } state_e;

  // multiplier operand select
  typedef enum logic {
    SEL_FILT,
    SEL_ANG
  } mul_sel_e;

  typedef struct packed {
    logic     busy;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     filt_upd;
    logic     out_load;
  } ctrl_t;

endpackage
`default_nettype wire

// File: design/ase_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ase_mul: shared signed-by-Q0.16 multiplier with round-half-up output
// Product is registered; the rounded integer is taken from the register.
// ----------------------------------------------------------------------------
module ase_mul (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [ase_pkg::DIFF_W-1:0] a_i,
  input  wire logic        [ase_pkg::COEF_W-1:0] b_i,
  output logic signed      [ase_pkg::RND_W-1:0]  rnd_o
);
  import ase_pkg::*;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_W - 1);

  logic signed [PROD_W-1:0] prod_d, prod_q, biased;

  // coefficient is unsigned, so widen it with a zero sign bit
  assign prod_d = PROD_W'(a_i) * PROD_W'($signed({1'b0, b_i}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // floor((p + 2^15) / 2^16): bias then drop the fraction bits
  assign biased = prod_q + $signed(ROUND_HALF);
  assign rnd_o  = biased[PROD_W-1:COEF_W];

endmodule
`default_nettype wire

// File: design/ase_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ase_ctrl: item sequencer
// Steps one item through filter multiply and filter update (primed samples only),
// angle multiply and result load, sharing the one multiplier.
// ----------------------------------------------------------------------------
module ase_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire ase_pkg::op_e  op_i,
  input  wire logic          primed_i,
  input  wire logic          out_free_i,
  output ase_pkg::ctrl_t     ctrl_o
);
  import ase_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (fire_i) begin
          // an unprimed filter loads directly and needs no multiply
          state_d = (op_i == OP_SAMPLE && primed_i) ? ST_FMUL : ST_AMUL;
        end
      end
      ST_FMUL: state_d = ST_FUPD;
      ST_FUPD: state_d = ST_AMUL;
      ST_AMUL: state_d = ST_AOUT;
      ST_AOUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.busy     = (state_q != ST_IDLE);
    ctrl_o.mul_sel  = SEL_FILT;
    case (state_q)
      ST_FMUL: ctrl_o.mul_en = 1'b1;
      ST_FUPD: ctrl_o.filt_upd = 1'b1;
      ST_AMUL: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = SEL_ANG;
      end
      ST_AOUT: ctrl_o.out_load = out_free_i;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: design/angle_sensor_ema_zeroing_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// angle_sensor_ema_zeroing_core: ADC sample EMA filter with zero offset
// Validity window, first-sample priming, zero capture/load and saturated
// signed angle output, all through one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid_i/in_stall_o| op_i, sample_i, zero_value_i
//  out     | out_valid_o/out_stall_i | raw_out_o, filtered_out_o, zero_out_o,
//          |                      | valid_out_o, angle_out_o
//  cfg     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
//  A sample on a primed filter makes two passes through the shared multiplier,
//  each followed by a register stage; other items make only the angle pass.
//  in_stall_o is high while an item is in the sequencer. The result beat sits
//  in an output register; a stalled output holds the sequencer in its last
//  step only until that register frees up.
//  Reset is asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module angle_sensor_ema_zeroing_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [ase_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [ase_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          op_i,
  input  wire logic [ase_pkg::ADC_BITS-1:0]        sample_i,
  input  wire logic [ase_pkg::VAL_BITS-1:0]        zero_value_i,
  // output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [ase_pkg::ADC_BITS-1:0]             raw_out_o,
  output logic [ase_pkg::VAL_BITS-1:0]             filtered_out_o,
  output logic [ase_pkg::VAL_BITS-1:0]             zero_out_o,
  output logic                                     valid_out_o,
  output logic signed [ase_pkg::ANG_BITS-1:0]      angle_out_o
);
  import ase_pkg::*;

  localparam logic signed [ANG_BITS-1:0] ANG_MAX = {1'b0, {VAL_BITS{1'b1}}};
  localparam logic signed [ANG_BITS-1:0] ANG_MIN = {1'b1, {VAL_BITS{1'b0}}};

  // configuration registers
  logic [ADC_BITS-1:0] valid_min_q, valid_max_q;
  logic [COEF_W-1:0]   alpha_q, dpc_q;
  logic                negate_q;

  // filter state
  logic [ADC_BITS-1:0] last_raw_q;
  logic [VAL_BITS-1:0] filtered_q, zero_q;
  logic                primed_q, sample_valid_q;

  // output register
  logic                       out_valid_q;
  logic [ADC_BITS-1:0]        out_raw_q;
  logic [VAL_BITS-1:0]        out_filt_q, out_zero_q;
  logic                       out_sv_q;
  logic signed [ANG_BITS-1:0] out_ang_q;

  ctrl_t                     ctrl;
  op_e                       in_op;
  logic                      in_fire, out_free;
  logic [VAL_BITS-1:0]       samp_val;
  logic signed [DIFF_W-1:0]  filt_diff, ang_diff, ang_term, mul_a;
  logic [COEF_W-1:0]         mul_b;
  logic signed [RND_W-1:0]   rnd;
  logic signed [SUM_W-1:0]   filt_sum;
  logic [VAL_BITS-1:0]       filt_next;
  logic signed [ANG_BITS-1:0] ang_sat;

  assign in_op      = op_e'(op_i);
  assign in_stall_o = ctrl.busy;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // configuration writes; default_zero only matters at reset, when it holds
  // its reset value, so a write to it is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_min_q <= RST_VALID_MIN;
      valid_max_q <= RST_VALID_MAX;
      alpha_q     <= RST_ALPHA;
      negate_q    <= RST_ANGLE_NEGATE;
      dpc_q       <= RST_DEG_PER_CNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VALID_MIN:    valid_min_q <= cfg_data_i[ADC_BITS-1:0];
        CFG_VALID_MAX:    valid_max_q <= cfg_data_i[ADC_BITS-1:0];
        CFG_ALPHA:        alpha_q     <= cfg_data_i[COEF_W-1:0];
        CFG_ANGLE_NEGATE: negate_q    <= cfg_data_i[0];
        CFG_DEG_PER_CNT:  dpc_q       <= cfg_data_i[COEF_W-1:0];
        CFG_DEFAULT_ZERO: ;
        default: ;
      endcase
    end
  end

  // sequencer
  ase_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .op_i       (in_op),
    .primed_i   (primed_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // multiplier operands
  assign samp_val  = {last_raw_q, FRAC_BITS'(0)};
  assign filt_diff = DIFF_W'(samp_val) - DIFF_W'(filtered_q);
  assign ang_diff  = DIFF_W'(filtered_q) - DIFF_W'(zero_q);
  assign ang_term  = negate_q ? -ang_diff : ang_diff;
  assign mul_a     = (ctrl.mul_sel == SEL_ANG) ? ang_term : filt_diff;
  assign mul_b     = (ctrl.mul_sel == SEL_ANG) ? dpc_q : alpha_q;

  ase_mul u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .rnd_o (rnd)
  );

  // filter step with clamp to the unsigned range
  assign filt_sum = SUM_W'(filtered_q) + SUM_W'(rnd);
  always_comb begin
    if (filt_sum[SUM_W-1]) begin
      filt_next = '0;
    end else if (|filt_sum[SUM_W-2:VAL_BITS]) begin
      filt_next = '1;
    end else begin
      filt_next = filt_sum[VAL_BITS-1:0];
    end
  end

  // angle saturation: overflow when the dropped top bits differ from the sign
  always_comb begin
    if (rnd[RND_W-1:ANG_BITS-1] == '0 || rnd[RND_W-1:ANG_BITS-1] == '1) begin
      ang_sat = rnd[ANG_BITS-1:0];
    end else if (rnd[RND_W-1]) begin
      ang_sat = ANG_MIN;
    end else begin
      ang_sat = ANG_MAX;
    end
  end

  // filter and zero state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q     <= '0;
      filtered_q     <= RST_DEFAULT_ZERO;
      zero_q         <= RST_DEFAULT_ZERO;
      primed_q       <= 1'b0;
      sample_valid_q <= 1'b0;
    end else if (in_fire) begin
      case (in_op)
        OP_SAMPLE: begin
          last_raw_q     <= sample_i;
          sample_valid_q <= (sample_i > valid_min_q) && (sample_i < valid_max_q);
          if (!primed_q) begin
            filtered_q <= {sample_i, FRAC_BITS'(0)};
            primed_q   <= 1'b1;
          end
        end
        OP_CAPTURE: begin
          if (sample_valid_q) begin
            zero_q <= filtered_q;
          end
        end
        OP_LOAD: zero_q <= zero_value_i;
        default: ;
      endcase
    end else if (ctrl.filt_upd) begin
      filtered_q <= filt_next;
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_raw_q  <= last_raw_q;
      out_filt_q <= filtered_q;
      out_zero_q <= zero_q;
      out_sv_q   <= sample_valid_q;
      out_ang_q  <= ang_sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign raw_out_o      = out_raw_q;
  assign filtered_out_o = out_filt_q;
  assign zero_out_o     = out_zero_q;
  assign valid_out_o    = out_sv_q;
  assign angle_out_o    = out_ang_q;

`ifndef SYNTHESIS
  // an accepted item always occupies the sequencer next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("accepted item did not start the sequencer");

  // the filter never returns to its unprimed state
  a_primed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(primed_q))
    else $error("primed flag dropped");

  // a valid sample implies the filter has been primed
  a_valid_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_q |-> primed_q)
    else $error("sample valid without primed filter");

  // the zero offset only moves at an accepted item
  a_zero_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(zero_q))
    else $error("zero offset changed without an item");

  // the multiplier is only used while an item is in flight
  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.mul_en || ctrl.out_load) |-> in_stall_o)
    else $error("datapath active while idle");
`endif

endmodule
`default_nettype wire
